// ===== src/m2ds_pkg.sv =====
package m2ds_pkg;

  localparam int unsigned ChW          = 8;     // one color channel
  localparam int unsigned CfgW         = 12;    // in_width / in_height registers
  localparam int unsigned MaxWidthDef  = 2048;
  localparam int unsigned WidthRst     = 640;
  localparam int unsigned HeightRst    = 480;
  localparam int unsigned ApbAddrW     = 3;
  localparam int unsigned ApbDataW     = 32;
  localparam int unsigned DivThreeMul  = 683;   // 2^11 / 3, rounded up
  localparam int unsigned DivThreeSh   = 11;

  typedef enum logic {
    RegInWidth  = 1'b0,
    RegInHeight = 1'b1
  } reg_idx_e;

  // One pixel after masking: colors and masked count.
  typedef struct packed {
    logic [ChW-1:0] blue;
    logic [ChW-1:0] green;
    logic [ChW-1:0] red;
    logic           n;
  } pix_t;

  // Sum over a horizontal pair: one line buffer entry.
  typedef struct packed {
    logic [ChW:0] blue;
    logic [ChW:0] green;
    logic [ChW:0] red;
    logic [1:0]   n;
  } pair_sum_t;

  // Sum over a whole 2x2 block.
  typedef struct packed {
    logic [ChW+1:0] blue;
    logic [ChW+1:0] green;
    logic [ChW+1:0] red;
    logic [2:0]     n;
  } blk_sum_t;

  // Averaged output pixel.
  typedef struct packed {
    logic [ChW-1:0] blue;
    logic [ChW-1:0] green;
    logic [ChW-1:0] red;
    logic           mask;
  } avg_pix_t;

endpackage

// ===== src/masked_2x2_downsample_top.sv =====
// Masked 2x2 box downsampler. Pixels stream in raster order on the slave side
// (tdata = red, green, blue from the low byte up; tuser = constraint mask).
// For each 2x2 block one word leaves on the master side carrying the rounded
// average of only the masked pixels, tuser set when any pixel was masked
// (color zero otherwise) and tlast on the last block of the frame. A trailing
// odd column or odd row is consumed without output. The block takes one word
// per clock unless both output stages are full: the top row of each block is
// kept as per-column pair sums in a single-port-write, single-port-read line
// buffer of MAX_WIDTH/2 entries with a registered read; after the block's
// lower-right word the result passes through a read stage and an output
// register that absorb back-pressure without stalling input until both
// are full. Width is clamped to 2..MAX_WIDTH, height to at least 2. Any
// write to in_width (0x0) or in_height (0x4) restarts the frame; write only
// while the stream is idle. The line buffer needs no clearing after reset:
// every entry is written in a block's top row before its bottom row reads it.
module masked_2x2_downsample_top #(
  parameter int unsigned MAX_WIDTH = m2ds_pkg::MaxWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // slave side
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [3*m2ds_pkg::ChW-1:0]    s_axis_tdata,   // red, green, blue
  input  logic                          s_axis_tuser,   // constrained
  // master side
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [3*m2ds_pkg::ChW-1:0]    m_axis_tdata,   // red, green, blue
  output logic                          m_axis_tuser,   // mask_out
  output logic                          m_axis_tlast,   // frame_end
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [m2ds_pkg::ApbAddrW-1:0] paddr,
  input  logic [m2ds_pkg::ApbDataW-1:0] pwdata,
  output logic [m2ds_pkg::ApbDataW-1:0] prdata,
  output logic                          pready
);

  localparam int unsigned CfgW    = m2ds_pkg::CfgW;
  localparam int unsigned ChW     = m2ds_pkg::ChW;
  localparam int unsigned CmpW    = CfgW + 2;
  localparam int unsigned BufDep  = MAX_WIDTH / 2;
  localparam int unsigned BufAw   = (BufDep > 1) ? $clog2(BufDep) : 1;
  localparam int unsigned EntryW  = $bits(m2ds_pkg::pair_sum_t);

  // ---------------------------------------------------------------- config
  logic [CfgW-1:0]    width_q, height_q;
  logic               cfg_wr;
  m2ds_pkg::reg_idx_e cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = m2ds_pkg::reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CfgW'(m2ds_pkg::WidthRst);
      height_q <= CfgW'(m2ds_pkg::HeightRst);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        m2ds_pkg::RegInWidth:  width_q  <= pwdata[CfgW-1:0];
        m2ds_pkg::RegInHeight: height_q <= pwdata[CfgW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      m2ds_pkg::RegInWidth:  prdata = m2ds_pkg::ApbDataW'(width_q);
      m2ds_pkg::RegInHeight: prdata = m2ds_pkg::ApbDataW'(height_q);
      default:               prdata = '0;
    endcase
  end

  // Clamp the frame size; derive the even extents that hold whole blocks.
  logic [CfgW-1:0] eff_w, eff_h, even_w, even_h;

  always_comb begin
    if (width_q < CfgW'(2)) begin
      eff_w = CfgW'(2);
    end else if ({2'b00, width_q} > CmpW'(MAX_WIDTH)) begin
      eff_w = CfgW'(MAX_WIDTH);
    end else begin
      eff_w = width_q;
    end
    eff_h  = (height_q < CfgW'(2)) ? CfgW'(2) : height_q;
    even_w = {eff_w[CfgW-1:1], 1'b0};
    even_h = {eff_h[CfgW-1:1], 1'b0};
  end

  // ---------------------------------------------------------- input stage
  logic            in_acc;
  logic [CfgW-1:0] col_q, col_d, row_q, row_d;
  m2ds_pkg::pix_t  pair_q, pair_d, px;
  m2ds_pkg::pair_sum_t row_sum;
  logic            in_block, buf_wr, buf_rd, blk_last;
  logic [BufAw-1:0] buf_addr;

  // stage 1: waits for the line buffer read
  logic                s1_vld_q, s1_vld_d;
  m2ds_pkg::pair_sum_t s1_sum_q;
  logic                s1_last_q;
  // output register
  logic                out_vld_q, out_vld_d, out_adv;
  m2ds_pkg::avg_pix_t  out_pix_q;
  logic                out_last_q;

  assign out_adv       = ~out_vld_q | m_axis_tready;
  assign s_axis_tready = ~s1_vld_q | out_adv;
  assign in_acc        = s_axis_tvalid & s_axis_tready;

  // Drop the colors of unmasked pixels.
  always_comb begin
    px.red   = s_axis_tuser ? s_axis_tdata[ChW-1:0]     : '0;
    px.green = s_axis_tuser ? s_axis_tdata[2*ChW-1:ChW] : '0;
    px.blue  = s_axis_tuser ? s_axis_tdata[3*ChW-1:2*ChW] : '0;
    px.n     = s_axis_tuser;
  end

  always_comb begin
    row_sum.red   = {1'b0, pair_q.red}   + {1'b0, px.red};
    row_sum.green = {1'b0, pair_q.green} + {1'b0, px.green};
    row_sum.blue  = {1'b0, pair_q.blue}  + {1'b0, px.blue};
    row_sum.n     = {1'b0, pair_q.n}     + {1'b0, px.n};
  end

  assign in_block = (col_q < even_w) && (row_q < even_h);
  assign buf_wr   = in_acc & in_block & col_q[0] & ~row_q[0];
  assign buf_rd   = in_acc & in_block & col_q[0] & row_q[0];
  assign buf_addr = BufAw'(col_q >> 1);
  assign blk_last = (col_q == even_w - CfgW'(1)) && (row_q == even_h - CfgW'(1));

  // Advance the raster position; a register write restarts the frame.
  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    pair_d = pair_q;
    if (cfg_wr) begin
      col_d  = '0;
      row_d  = '0;
      pair_d = '0;
    end else if (in_acc) begin
      if (in_block && !col_q[0]) begin
        pair_d = px;
      end
      if ({1'b0, col_q} + (CfgW+1)'(1) >= {1'b0, eff_w}) begin
        col_d = '0;
        if ({1'b0, row_q} + (CfgW+1)'(1) >= {1'b0, eff_h}) begin
          row_d = '0;
        end else begin
          row_d = row_q + CfgW'(1);
        end
      end else begin
        col_d = col_q + CfgW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      pair_q <= '0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      pair_q <= pair_d;
    end
  end

  // ---------------------------------------------------------- line buffer
  logic [EntryW-1:0]   buf_rdata;
  m2ds_pkg::pair_sum_t top_sum;

  m2ds_ram #(
    .DATA_W (EntryW),
    .DEPTH  (BufDep)
  ) u_line_buf (
    .clk_i   (clk_i),
    .we_i    (buf_wr),
    .waddr_i (buf_addr),
    .wdata_i (row_sum),
    .re_i    (buf_rd),
    .raddr_i (buf_addr),
    .rdata_o (buf_rdata)
  );

  assign top_sum = m2ds_pkg::pair_sum_t'(buf_rdata);

  // ------------------------------------------------------ stage 1 control
  always_comb begin
    s1_vld_d = s1_vld_q;
    if (buf_rd) begin
      s1_vld_d = 1'b1;
    end else if (out_adv) begin
      s1_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= s1_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (buf_rd) begin
      s1_sum_q  <= row_sum;
      s1_last_q <= blk_last;
    end
  end

  // --------------------------------------------------- block sum, average
  m2ds_pkg::blk_sum_t blk_sum;
  m2ds_pkg::avg_pix_t avg_pix;

  always_comb begin
    blk_sum.red   = {1'b0, top_sum.red}   + {1'b0, s1_sum_q.red};
    blk_sum.green = {1'b0, top_sum.green} + {1'b0, s1_sum_q.green};
    blk_sum.blue  = {1'b0, top_sum.blue}  + {1'b0, s1_sum_q.blue};
    blk_sum.n     = {1'b0, top_sum.n}     + {1'b0, s1_sum_q.n};
  end

  m2ds_avg u_avg (
    .sum_i (blk_sum),
    .pix_o (avg_pix)
  );

  // ------------------------------------------------------ output register
  always_comb begin
    out_vld_d = out_vld_q;
    if (out_adv) begin
      out_vld_d = s1_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  // Hold the word while the master side stalls.
  always_ff @(posedge clk_i) begin
    if (out_adv && s1_vld_q) begin
      out_pix_q  <= avg_pix;
      out_last_q <= s1_last_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_pix_q.blue, out_pix_q.green, out_pix_q.red};
  assign m_axis_tuser  = out_pix_q.mask;
  assign m_axis_tlast  = out_last_q;

endmodule

// ===== src/m2ds_ram.sv =====
module m2ds_ram #(
  parameter int unsigned DATA_W = 29,
  parameter int unsigned DEPTH  = 1024
) (
  input  logic                                clk_i,
  input  logic                                we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [DATA_W-1:0]                   wdata_i,
  input  logic                                re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [DATA_W-1:0]                   rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== src/m2ds_avg.sv =====
module m2ds_avg (
  input  m2ds_pkg::blk_sum_t sum_i,
  output m2ds_pkg::avg_pix_t pix_o
);

  // Round to nearest: (sum + n/2) / n for n in 1..4.
  function automatic logic [m2ds_pkg::ChW-1:0] div_round(
    input logic [m2ds_pkg::ChW+1:0] s,
    input logic [2:0]               n
  );
    logic [m2ds_pkg::ChW+2:0] x;
    logic [20:0]              prod;
    logic [m2ds_pkg::ChW-1:0] q;
    x    = {1'b0, s} + (m2ds_pkg::ChW+3)'(n >> 1);
    prod = 21'(x) * 21'(m2ds_pkg::DivThreeMul);
    unique case (n)
      3'd1:    q = m2ds_pkg::ChW'(x);
      3'd2:    q = m2ds_pkg::ChW'(x >> 1);
      3'd3:    q = m2ds_pkg::ChW'(prod >> m2ds_pkg::DivThreeSh);
      3'd4:    q = m2ds_pkg::ChW'(x >> 2);
      default: q = '0;
    endcase
    return q;
  endfunction

  always_comb begin
    pix_o.red   = div_round(sum_i.red,   sum_i.n);
    pix_o.green = div_round(sum_i.green, sum_i.n);
    pix_o.blue  = div_round(sum_i.blue,  sum_i.n);
    pix_o.mask  = (sum_i.n != 3'd0);
  end

endmodule

// ===== src/m2ds_chk.sv =====
module m2ds_chk (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       s_axis_tvalid,
  input logic                       s_axis_tready,
  input logic                       m_axis_tvalid,
  input logic                       m_axis_tready,
  input logic [3*m2ds_pkg::ChW-1:0] m_axis_tdata,
  input logic                       m_axis_tuser,
  input logic                       m_axis_tlast
);

  // A stalled word holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
      && $stable(m_axis_tlast))
    else $error("output word changed under stall");

  // A block with no masked pixel carries zero color.
  a_unmasked_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("unmasked block with nonzero color");

  // Input back-pressure only when the output is stalled.
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output back-pressure");

  // A new output word traces back to an accepted input word, through stage 1 and the output register.
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("output word without matching input word");

endmodule

bind masked_2x2_downsample_top m2ds_chk u_m2ds_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
